// ===== sv/wspm_pkg.sv =====
package wspm_pkg;

    localparam int CHAR_W           = 8;
    localparam int PAT_CHARS        = 4;
    localparam int WIN_W            = CHAR_W * PAT_CHARS;
    localparam int RECENT_W         = CHAR_W * (PAT_CHARS - 1);
    localparam int CNT_W            = $clog2(PAT_CHARS);
    localparam int LEN_LSB          = 32;
    localparam int LEN_W            = 3;
    localparam int CFG_W            = LEN_LSB + LEN_W;
    localparam int CFG_IDX_W        = 3;
    localparam int POS_W            = 32;
    localparam int MASK_W           = 8;
    localparam int NUM_PATTERNS_DEF = 8;
    localparam int MAX_HITS_DEF     = 10;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PAT_CHARS - 1);

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [CNT_W-1:0] chars;
    } wspm_window_t;

    typedef struct packed {
        logic [POS_W-1:0]  word_position;
        logic [MASK_W-1:0] match_mask;
        logic [MASK_W-1:0] recorded_mask;
    } wspm_result_t;

    function automatic logic [CHAR_W-1:0] lower_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c | 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // window byte 0 is the newest character
    function automatic logic pat_hit(input logic [CFG_W-1:0] pattern,
                                     input logic [WIN_W-1:0] window,
                                     input logic [CNT_W-1:0] chars);
        logic [LEN_W-1:0] len;
        logic             hit;
        int               k;
        len = pattern[CFG_W-1:LEN_LSB];
        hit = 1'b0;
        if (len != '0 && int'(len) <= PAT_CHARS && int'(chars) + 1 >= int'(len))
        begin
            hit = 1'b1;
            for (int j = 0; j < PAT_CHARS; j++)
            begin
                k = int'(len) - 1 - j;
                if (j < int'(len))
                begin
                    if (lower_char(pattern[CHAR_W*k +: CHAR_W]) != window[CHAR_W*j +: CHAR_W])
                    begin
                        hit = 1'b0;
                    end
                end
            end
        end
        return hit;
    endfunction

endpackage

// ===== sv/wspm_ifs.sv =====
interface wspm_byte_if import wspm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface wspm_cfg_if import wspm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface wspm_result_if import wspm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  word_position;
    logic [MASK_W-1:0] match_mask;
    logic [MASK_W-1:0] recorded_mask;

    modport source (output valid, output word_position, output match_mask,
                    output recorded_mask, input ready);
    modport sink   (input valid, input word_position, input match_mask,
                    input recorded_mask, output ready);
endinterface

// ===== sv/wspm_pattern_bank.sv =====
module wspm_pattern_bank import wspm_pkg::*; #(
    parameter int NUM_PATTERNS = NUM_PATTERNS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  wspm_window_t            win,
    output logic [NUM_PATTERNS-1:0] hits
);

    logic [CFG_W-1:0] pat_reg [NUM_PATTERNS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PATTERNS; i++)
            begin
                pat_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_PATTERNS; i++)
            begin
                if (cfg_wr && cfg_index == CFG_IDX_W'(i))
                begin
                    pat_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_PATTERNS; i++)
        begin
            hits[i] = pat_hit(pat_reg[i], win.window, win.chars);
        end
    end

endmodule

// ===== sv/wspm_word_tracker.sv =====
module wspm_word_tracker import wspm_pkg::*; #(
    parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
    parameter int MAX_HITS     = MAX_HITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [CHAR_W-1:0]       text_byte,
    input  logic [NUM_PATTERNS-1:0] hits,
    output wspm_window_t            win,
    output logic                    res_valid,
    output wspm_result_t            res
);

    localparam int HIT_W = $clog2(MAX_HITS + 1);

    logic [RECENT_W-1:0]     recent_reg, recent_next;
    logic [CNT_W-1:0]        chars_reg, chars_next;
    logic [NUM_PATTERNS-1:0] found_reg, found_next;
    logic [POS_W-1:0]        wpos_reg, wpos_next;
    logic [HIT_W-1:0]        count_reg [NUM_PATTERNS];
    logic [HIT_W-1:0]        count_next [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0] rec;

    always_comb
    begin
        win.window  = {recent_reg, lower_char(text_byte)};
        win.chars   = chars_reg;
        recent_next = recent_reg;
        chars_next  = chars_reg;
        found_next  = found_reg;
        wpos_next   = wpos_reg;
        count_next  = count_reg;
        rec         = '0;
        res_valid   = 1'b0;
        for (int i = 0; i < NUM_PATTERNS; i++)
        begin
            rec[i] = found_reg[i] && count_reg[i] < HIT_W'(MAX_HITS);
        end
        if (step)
        begin
            if (is_word_char(text_byte))
            begin
                found_next  = found_reg | hits;
                recent_next = win.window[RECENT_W-1:0];
                if (chars_reg != CNT_MAX)
                begin
                    chars_next = chars_reg + CNT_W'(1);
                end
            end
            else if (chars_reg != '0)
            begin
                res_valid = 1'b1;
                for (int i = 0; i < NUM_PATTERNS; i++)
                begin
                    if (rec[i])
                    begin
                        count_next[i] = count_reg[i] + HIT_W'(1);
                    end
                end
                if (wpos_reg != '1)
                begin
                    wpos_next = wpos_reg + POS_W'(1);
                end
                recent_next = '0;
                chars_next  = '0;
                found_next  = '0;
            end
        end
        res.word_position = wpos_reg;
        res.match_mask    = MASK_W'(found_reg);
        res.recorded_mask = MASK_W'(rec);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
            chars_reg  <= '0;
            found_reg  <= '0;
            wpos_reg   <= POS_W'(1);
            for (int i = 0; i < NUM_PATTERNS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            recent_reg <= recent_next;
            chars_reg  <= chars_next;
            found_reg  <= found_next;
            wpos_reg   <= wpos_next;
            count_reg  <= count_next;
        end
    end

    a_rec_in_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.recorded_mask & ~res.match_mask) == '0)
        else $error("recorded pattern not matched");

    a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        wpos_reg != '0)
        else $error("word position zero");

    a_word_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> chars_reg == '0 && found_reg == '0 && recent_reg == '0)
        else $error("word state not cleared after word end");

    a_found_empty: assert property (@(posedge clk) disable iff (!rst_n)
        chars_reg == '0 |-> found_reg == '0)
        else $error("flags set with no characters");

    generate
        for (genvar g = 0; g < NUM_PATTERNS; g++)
        begin : g_cnt_chk
            a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
                count_reg[g] <= HIT_W'(MAX_HITS))
                else $error("hit count above limit");
        end
    endgenerate

endmodule

// ===== sv/word_substring_pattern_matcher_core.sv =====
// Output: a byte is registered on acceptance; the word-ending byte's result is then
// registered in the result register when that byte advances, held there until taken.
// Throughput: one byte per cycle; the input stalls only while the result register
// is full and not being taken.
// Reset (rst_n, asynchronous, active low): patterns and hit counts cleared, word
// state empty, next word position 1.
module word_substring_pattern_matcher_core import wspm_pkg::*; #(
    parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
    parameter int MAX_HITS     = MAX_HITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    wspm_byte_if.sink      text,
    wspm_cfg_if.sink       cfg,
    wspm_result_if.source  result
);

    logic                    byte_valid_reg;
    logic [CHAR_W-1:0]       byte_reg;
    logic                    out_valid_reg;
    wspm_result_t            out_reg;
    logic                    out_free;
    logic                    advance;
    logic [NUM_PATTERNS-1:0] hits;
    wspm_window_t            win;
    logic                    res_valid;
    wspm_result_t            res;

    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = byte_valid_reg && out_free;
    assign text.ready = !byte_valid_reg || out_free;
    assign cfg.ready  = 1'b1;

    assign result.valid         = out_valid_reg;
    assign result.word_position = out_reg.word_position;
    assign result.match_mask    = out_reg.match_mask;
    assign result.recorded_mask = out_reg.recorded_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (text.valid && text.ready)
            begin
                byte_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                byte_valid_reg <= 1'b0;
            end
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            byte_reg <= text.text_byte;
        end
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    wspm_pattern_bank #(
        .NUM_PATTERNS (NUM_PATTERNS)
    ) u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg.valid && cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .win       (win),
        .hits      (hits)
    );

    wspm_word_tracker #(
        .NUM_PATTERNS (NUM_PATTERNS),
        .MAX_HITS     (MAX_HITS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .text_byte (byte_reg),
        .hits      (hits),
        .win       (win),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule
